// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// types, constants and helpers shared by the block allocator files
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int MAP_WORDS  = 256;
   localparam int WORD_BITS  = 16;
   localparam int BIT_IDX_W  = 4;
   localparam int BLOCK_W    = 12;
   localparam int WORD_IDX_W = BLOCK_W - BIT_IDX_W;
   localparam int SCAN_WORDS = 1 << WORD_IDX_W;
   localparam int MAP_DEPTH  = (MAP_WORDS < SCAN_WORDS) ? MAP_WORDS : SCAN_WORDS;
   localparam int RAM_AW     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [WORD_IDX_W-1:0] word_idx_type;

   typedef struct packed {
      logic                 found;
      logic [BIT_IDX_W-1:0] idx;
   } find_type;

   // bits of a word that may be handed out; block 0 is reserved
   function automatic word_type usable_mask(input word_idx_type w);
      return (w == '0) ? ~word_type'(1) : '1;
   endfunction

   function automatic logic word_is_full(input word_type d, input word_idx_type w);
      return &(d | ~usable_mask(w));
   endfunction

endpackage

// ===== rtl/bba_if.sv =====
// ----------------------------------------------------------------------------
// bba_if
// request and response channels of the block allocator
// ----------------------------------------------------------------------------
interface bba_req_if import bba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               func;
   logic [BLOCK_W-1:0] block;

   modport source (output valid, func, block, input ready);
   modport sink   (input valid, func, block, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BLOCK_W-1:0] block_res;
   logic               ok;

   modport source (output valid, block_res, ok, input ready);
   modport sink   (input valid, block_res, ok, output ready);
endinterface

// ===== rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/bba_find.sv =====
// ----------------------------------------------------------------------------
// bba_find
// shared lowest-set-bit finder over one sixteen-bit vector
// ----------------------------------------------------------------------------
module bba_find import bba_pkg::*; (
   input  word_type bits,
   output find_type res
);

   always_comb begin
      res.found = |bits;
      res.idx   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            res.idx = BIT_IDX_W'(i);
         end
      end
   end

endmodule

// ===== rtl/bitmap_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// first-fit block allocator over a used-block bitmap of sixteen-bit words
// ----------------------------------------------------------------------------
// req_ch carries one item: func (allocate or free) and block (used by free).
// rsp_ch returns one item for each request: block_res and ok.
// allocate hands out the lowest free block, never block 0; ok is low when
// the map is full, and block_res is then zero. free clears the block's bit
// and echoes the block with ok high.
// the bitmap lives in one ram; a flip-flop full bit per word and a 16-bit
// group summary on top steer the search, so a single finder is reused for
// group, word and bit in turn.
// allocate steps through accept, group, word and bit; free steps through
// accept and a read-modify-write; a full map answers from the group
// step. the ram read and the three finder passes shape these steps.
// one item at a time: req_ch.ready is high only while the sequencer idles.
// reset: per-word valid and full bits clear at once, a word never written
// reads as zero, so there is no clearing pass and req_ch is ready at once.
// a stalled receiver holds the result in the output register; the
// sequencer waits in its last step until that register is free.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit import bba_pkg::*; (
   input logic       clock,
   input logic       reset,
   bba_req_if.sink   req_ch,
   bba_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_GROUP,
      S_WORD,
      S_BIT,
      S_FREE
   } state_type;

   state_type          state_ff, state_in;
   logic [BLOCK_W-1:0] block_ff, block_in;
   logic [BIT_IDX_W-1:0] group_ff, group_in;
   word_idx_type       word_ff, word_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0] rsp_block_ff, rsp_block_in;
   logic               rsp_ok_ff, rsp_ok_in;

   // per-word status in flip-flops
   logic [SCAN_WORDS-1:0] full_ff;
   logic [SCAN_WORDS-1:0] valid_ff;
   logic                  rd_valid_ff;

   logic [SCAN_WORDS-1:0] word_full;
   logic [WORD_BITS-1:0]  group_full;
   logic                  slot_free;
   logic                  in_map;
   word_idx_type          rd_word;
   word_type              rd_data;
   word_type              cur_word;
   word_type              wr_data;
   logic                  wr_en;
   word_type              find_bits;
   find_type              find;

   // words past the map never take part in the search
   always_comb begin
      for (int i = 0; i < SCAN_WORDS; i++) begin
         word_full[i] = full_ff[i] | (i >= MAP_DEPTH);
      end
      for (int g = 0; g < WORD_BITS; g++) begin
         group_full[g] = &word_full[g*WORD_BITS +: WORD_BITS];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign in_map    = ({1'b0, word_ff} < (WORD_IDX_W + 1)'(MAP_DEPTH));
   // a word that was never written reads as all free
   assign cur_word  = rd_valid_ff ? rd_data : '0;

   // the finder input follows the sequencer step
   always_comb begin
      case (state_ff)
         S_GROUP: find_bits = ~group_full;
         S_WORD:  find_bits = ~word_full[{group_ff, BIT_IDX_W'(0)} +: WORD_BITS];
         S_BIT:   find_bits = ~cur_word & usable_mask(word_ff);
         default: find_bits = '0;
      endcase
   end

   bba_find u_find (
      .bits (find_bits),
      .res  (find)
   );

   always_comb begin
      state_in     = state_ff;
      block_in     = block_ff;
      group_in     = group_ff;
      word_in      = word_ff;
      rsp_block_in = rsp_block_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rd_word      = word_ff;
      wr_en        = 1'b0;
      wr_data      = cur_word;
      req_ch.ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               block_in = req_ch.block;
               if (req_ch.func == FUNC_FREE) begin
                  word_in  = req_ch.block[BLOCK_W-1:BIT_IDX_W];
                  rd_word  = req_ch.block[BLOCK_W-1:BIT_IDX_W];
                  state_in = S_FREE;
               end else begin
                  state_in = S_GROUP;
               end
            end
         end
         S_GROUP: begin
            if (find.found) begin
               group_in = find.idx;
               state_in = S_WORD;
            end else if (slot_free) begin
               // map full
               rsp_valid_in = 1'b1;
               rsp_block_in = '0;
               rsp_ok_in    = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_WORD: begin
            word_in  = {group_ff, find.idx};
            rd_word  = {group_ff, find.idx};
            state_in = S_BIT;
         end
         S_BIT: begin
            if (slot_free) begin
               wr_en        = 1'b1;
               wr_data      = cur_word | (word_type'(1) << find.idx);
               rsp_valid_in = 1'b1;
               rsp_block_in = {word_ff, find.idx};
               rsp_ok_in    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FREE: begin
            if (slot_free) begin
               wr_en        = in_map;
               wr_data      = cur_word & ~(word_type'(1) << block_ff[BIT_IDX_W-1:0]);
               rsp_valid_in = 1'b1;
               rsp_block_in = block_ff;
               rsp_ok_in    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      block_ff     <= block_in;
      group_ff     <= group_in;
      word_ff      <= word_in;
      rsp_block_ff <= rsp_block_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   // word status, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= '0;
         valid_ff <= '0;
      end else if (wr_en) begin
         full_ff[word_ff]  <= word_is_full(wr_data, word_ff);
         valid_ff[word_ff] <= 1'b1;
      end
      rd_valid_ff <= valid_ff[rd_word];
   end

   bba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff[RAM_AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_word[RAM_AW-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.block_res = rsp_block_ff;
   assign rsp_ch.ok        = rsp_ok_ff;

`ifndef SYNTHESIS
   // a group that is not full always holds a word with a free bit
   a_word_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WORD) |-> find.found)
      else $error("no free word in a group marked not full");

   // the chosen word has a free bit, and block 0 is never handed out
   a_bit_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BIT) |-> (find.found && ({word_ff, find.idx} != '0)))
      else $error("bad bit chosen in allocate");

   // the full bit tracks the word just written
   a_full_track: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (full_ff[$past(word_ff)] == word_is_full($past(wr_data), $past(word_ff))))
      else $error("full bit out of step with map word");

   // a failed allocate reports block zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_block_ff == '0))
      else $error("failed allocate with nonzero block");
`endif

endmodule
